### rtl/sts_pkg.sv
// shared types, token kind codes and character helpers for the script token scanner
// no dependencies; used by sts_step, sts_outq and script_token_scanner
package sts_pkg;

  typedef logic [15:0] loc_t;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_PLUS,
    MODE_MINUS,
    MODE_BANG,
    MODE_STRING,
    MODE_INT,
    MODE_FRAC,
    MODE_IDENT
  } mode_t;

  localparam logic [5:0] K_END       = 6'd0;
  localparam logic [5:0] K_LBRACKET  = 6'd1;
  localparam logic [5:0] K_COMMA     = 6'd2;
  localparam logic [5:0] K_RBRACKET  = 6'd3;
  localparam logic [5:0] K_LPAREN    = 6'd4;
  localparam logic [5:0] K_RPAREN    = 6'd5;
  localparam logic [5:0] K_LBRACE    = 6'd6;
  localparam logic [5:0] K_RBRACE    = 6'd7;
  localparam logic [5:0] K_LESS      = 6'd8;
  localparam logic [5:0] K_GREATER   = 6'd9;
  localparam logic [5:0] K_PLUS      = 6'd10;
  localparam logic [5:0] K_INCR      = 6'd11;
  localparam logic [5:0] K_MINUS     = 6'd12;
  localparam logic [5:0] K_DECR      = 6'd13;
  localparam logic [5:0] K_STAR      = 6'd14;
  localparam logic [5:0] K_SLASH     = 6'd15;
  localparam logic [5:0] K_NOT_EQUAL = 6'd16;
  localparam logic [5:0] K_ASSIGN    = 6'd17;
  localparam logic [5:0] K_SEMI      = 6'd18;
  localparam logic [5:0] K_DOT       = 6'd19;
  localparam logic [5:0] K_ILLEGAL   = 6'd20;
  localparam logic [5:0] K_STRING    = 6'd21;
  localparam logic [5:0] K_NUMBER    = 6'd22;
  localparam logic [5:0] K_BOOLEAN   = 6'd23;
  localparam logic [5:0] K_NULL      = 6'd24;
  localparam logic [5:0] K_VAR       = 6'd25;
  localparam logic [5:0] K_FUNCTION  = 6'd26;
  localparam logic [5:0] K_DECLARE   = 6'd27;
  localparam logic [5:0] K_IF        = 6'd28;
  localparam logic [5:0] K_ELSE      = 6'd29;
  localparam logic [5:0] K_THIS      = 6'd30;
  localparam logic [5:0] K_NEW       = 6'd31;
  localparam logic [5:0] K_WHILE     = 6'd32;
  localparam logic [5:0] K_RETURN    = 6'd33;
  localparam logic [5:0] K_IDENT     = 6'd34;

  localparam int unsigned KeywordMaxChars = 8;

  typedef struct packed {
    mode_t        mode;
    logic [7:0]   quote;
    logic [63:0]  window;
    logic         overflow;
    loc_t         pos;
    loc_t         line;
    loc_t         col;
    loc_t         start_pos;
    loc_t         start_line;
    loc_t         start_col;
    logic [15:0]  count;
  } state_t;

  typedef struct packed {
    logic [5:0]  kind;
    loc_t        pos;
    loc_t        line;
    loc_t        col;
    logic [15:0] len;
    logic        last;
  } tok_t;

  typedef struct packed {
    logic [2:0] count;
    logic       full;
  } q_status_t;

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == 16'hffff) ? v : v + 16'd1;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_ident_start(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) ||
           (c == "$") || (c == "_");
  endfunction

  // keywords packed one byte per char, first char in the high byte
  function automatic logic [5:0] ident_kind(input logic [63:0] w, input logic ovf);
    logic [5:0] k;
    k = K_IDENT;
    if (!ovf) begin
      case (w)
        64'h766172:           k = K_VAR;
        64'h66756e6374696f6e: k = K_FUNCTION;
        64'h6465636c617265:   k = K_DECLARE;
        64'h6966:             k = K_IF;
        64'h656c7365:         k = K_ELSE;
        64'h74727565:         k = K_BOOLEAN;
        64'h74686973:         k = K_THIS;
        64'h66616c7365:       k = K_BOOLEAN;
        64'h6e756c6c:         k = K_NULL;
        64'h6e6577:           k = K_NEW;
        64'h7768696c65:       k = K_WHILE;
        64'h72657475726e:     k = K_RETURN;
        default:              k = K_IDENT;
      endcase
    end
    return k;
  endfunction

endpackage

### rtl/sts_step.sv
// per-byte scan logic: next scanner state and up to two tokens for one item
// depends on sts_pkg
module sts_step (
  input  logic [7:0]      c,
  input  sts_pkg::state_t st,
  output sts_pkg::state_t st_next,
  output sts_pkg::tok_t   res0,
  output sts_pkg::tok_t   res1,
  output logic [1:0]      res_cnt
);

  sts_pkg::state_t s;
  sts_pkg::tok_t   held_tok;
  sts_pkg::tok_t   idle_tok;
  logic            held_emit;
  logic            idle_emit;
  logic            rescan;
  logic [5:0]      idle_kind;
  logic            idle_adv;

  always_comb begin
    s         = st;
    held_emit = 1'b0;
    rescan    = 1'b1;
    held_tok  = '{kind: sts_pkg::K_END, pos: st.start_pos, line: st.start_line,
                  col: st.start_col, len: 16'd0, last: 1'b0};

    // finish or extend the token that is held from earlier bytes
    case (st.mode)
      sts_pkg::MODE_PLUS, sts_pkg::MODE_MINUS: begin
        s.mode    = sts_pkg::MODE_IDLE;
        held_emit = 1'b1;
        if ((st.mode == sts_pkg::MODE_PLUS && c == "+") ||
            (st.mode == sts_pkg::MODE_MINUS && c == "-")) begin
          s.pos         = sts_pkg::sat_inc(st.pos);
          s.col         = sts_pkg::sat_inc(st.col);
          held_tok.kind = (st.mode == sts_pkg::MODE_PLUS) ? sts_pkg::K_INCR : sts_pkg::K_DECR;
          held_tok.len  = 16'd2;
          rescan        = 1'b0;
        end else begin
          held_tok.kind = (st.mode == sts_pkg::MODE_PLUS) ? sts_pkg::K_PLUS : sts_pkg::K_MINUS;
          held_tok.len  = 16'd1;
        end
      end
      sts_pkg::MODE_BANG: begin
        s.mode    = sts_pkg::MODE_IDLE;
        held_emit = 1'b1;
        if (c == "=") begin
          s.pos         = sts_pkg::sat_inc(st.pos);
          s.col         = sts_pkg::sat_inc(st.col);
          held_tok.kind = sts_pkg::K_NOT_EQUAL;
          held_tok.len  = 16'd2;
          rescan        = 1'b0;
        end else begin
          held_tok.kind = sts_pkg::K_ILLEGAL;
          held_tok.len  = 16'd1;
        end
      end
      sts_pkg::MODE_STRING: begin
        if (c == st.quote && c != 8'd0) begin
          held_emit     = 1'b1;
          held_tok.kind = sts_pkg::K_STRING;
          held_tok.len  = st.count;
          s.pos         = sts_pkg::sat_inc(st.pos);
          s.col         = sts_pkg::sat_inc(st.col);
          s.mode        = sts_pkg::MODE_IDLE;
          rescan        = 1'b0;
        end else if (c == 8'd0) begin
          // open string at end of stream
          held_emit     = 1'b1;
          held_tok.kind = sts_pkg::K_STRING;
          held_tok.len  = st.count;
          s.mode        = sts_pkg::MODE_IDLE;
        end else begin
          s.count = sts_pkg::sat_inc(st.count);
          s.pos   = sts_pkg::sat_inc(st.pos);
          s.col   = sts_pkg::sat_inc(st.col);
          rescan  = 1'b0;
        end
      end
      sts_pkg::MODE_INT, sts_pkg::MODE_FRAC: begin
        if (sts_pkg::is_digit(c) || (c == "." && st.mode == sts_pkg::MODE_INT)) begin
          if (c == ".") s.mode = sts_pkg::MODE_FRAC;
          s.count = sts_pkg::sat_inc(st.count);
          s.pos   = sts_pkg::sat_inc(st.pos);
          s.col   = sts_pkg::sat_inc(st.col);
          rescan  = 1'b0;
        end else begin
          held_emit     = 1'b1;
          held_tok.kind = sts_pkg::K_NUMBER;
          held_tok.len  = st.count;
          s.mode        = sts_pkg::MODE_IDLE;
        end
      end
      sts_pkg::MODE_IDENT: begin
        if (sts_pkg::is_ident_start(c) || sts_pkg::is_digit(c)) begin
          if (st.count >= 16'(sts_pkg::KeywordMaxChars)) s.overflow = 1'b1;
          else s.window = {st.window[55:0], c};
          s.count = sts_pkg::sat_inc(st.count);
          s.pos   = sts_pkg::sat_inc(st.pos);
          s.col   = sts_pkg::sat_inc(st.col);
          rescan  = 1'b0;
        end else begin
          held_emit     = 1'b1;
          held_tok.kind = sts_pkg::ident_kind(st.window, st.overflow);
          held_tok.len  = st.count;
          s.mode        = sts_pkg::MODE_IDLE;
        end
      end
      default: begin
        s.mode = sts_pkg::MODE_IDLE;
      end
    endcase

    // scan the byte as the start of a new token
    idle_emit = 1'b0;
    idle_kind = sts_pkg::K_ILLEGAL;
    idle_adv  = 1'b1;
    idle_tok  = '{kind: sts_pkg::K_END, pos: s.pos, line: s.line, col: s.col,
                  len: 16'd1, last: 1'b0};
    if (rescan) begin
      s.start_pos  = s.pos;
      s.start_line = s.line;
      s.start_col  = s.col;
      s.mode       = sts_pkg::MODE_IDLE;
      case (c)
        8'd0: begin
          idle_emit = 1'b1;
          idle_kind = sts_pkg::K_END;
          idle_adv  = 1'b0;
        end
        "[": begin idle_emit = 1'b1; idle_kind = sts_pkg::K_LBRACKET; end
        ",": begin idle_emit = 1'b1; idle_kind = sts_pkg::K_COMMA;    end
        "]": begin idle_emit = 1'b1; idle_kind = sts_pkg::K_RBRACKET; end
        "(": begin idle_emit = 1'b1; idle_kind = sts_pkg::K_LPAREN;   end
        ")": begin idle_emit = 1'b1; idle_kind = sts_pkg::K_RPAREN;   end
        "{": begin idle_emit = 1'b1; idle_kind = sts_pkg::K_LBRACE;   end
        "}": begin idle_emit = 1'b1; idle_kind = sts_pkg::K_RBRACE;   end
        "<": begin idle_emit = 1'b1; idle_kind = sts_pkg::K_LESS;     end
        ">": begin idle_emit = 1'b1; idle_kind = sts_pkg::K_GREATER;  end
        "*": begin idle_emit = 1'b1; idle_kind = sts_pkg::K_STAR;     end
        "/": begin idle_emit = 1'b1; idle_kind = sts_pkg::K_SLASH;    end
        "=": begin idle_emit = 1'b1; idle_kind = sts_pkg::K_ASSIGN;   end
        ";": begin idle_emit = 1'b1; idle_kind = sts_pkg::K_SEMI;     end
        ".": begin idle_emit = 1'b1; idle_kind = sts_pkg::K_DOT;      end
        "+": s.mode = sts_pkg::MODE_PLUS;
        "-": s.mode = sts_pkg::MODE_MINUS;
        "!": s.mode = sts_pkg::MODE_BANG;
        8'h22, 8'h27: begin
          s.quote = c;
          s.count = 16'd0;
          s.mode  = sts_pkg::MODE_STRING;
        end
        " ", 8'h09: ;
        8'h0a: begin
          // newline moves to the next line, column back to zero
          idle_adv = 1'b0;
          s.line   = sts_pkg::sat_inc(s.line);
          s.pos    = sts_pkg::sat_inc(s.pos);
          s.col    = 16'd0;
        end
        default: begin
          if (sts_pkg::is_digit(c)) begin
            s.count = 16'd1;
            s.mode  = sts_pkg::MODE_INT;
          end else if (sts_pkg::is_ident_start(c)) begin
            s.window   = {56'd0, c};
            s.overflow = 1'b0;
            s.count    = 16'd1;
            s.mode     = sts_pkg::MODE_IDENT;
          end else begin
            idle_emit = 1'b1;
            idle_kind = sts_pkg::K_ILLEGAL;
          end
        end
      endcase
      idle_tok.kind = idle_kind;
      idle_tok.len  = (idle_kind == sts_pkg::K_END) ? 16'd0 : 16'd1;
      if (idle_adv) begin
        s.pos = sts_pkg::sat_inc(s.pos);
        s.col = sts_pkg::sat_inc(s.col);
      end
    end
    st_next = s;
  end

  // order: the held token first, then the one this byte makes itself
  always_comb begin
    res0    = held_tok;
    res1    = idle_tok;
    res_cnt = 2'd0;
    if (held_emit && idle_emit) begin
      res0.last = 1'b0;
      res1.last = 1'b1;
      res_cnt   = 2'd2;
    end else if (held_emit) begin
      res0.last = 1'b1;
      res_cnt   = 2'd1;
    end else if (idle_emit) begin
      res0      = idle_tok;
      res0.last = 1'b1;
      res_cnt   = 2'd1;
    end
  end

endmodule

### rtl/sts_outq.sv
// four-entry result queue taking up to two tokens per cycle, one out per cycle
// depends on sts_pkg
module sts_outq (
  input  logic                clk,
  input  logic                rst,
  input  logic [1:0]          push_cnt,
  input  sts_pkg::tok_t       push0,
  input  sts_pkg::tok_t       push1,
  input  logic                pop,
  output logic                head_valid,
  output sts_pkg::tok_t       head,
  output sts_pkg::q_status_t  status
);

  sts_pkg::tok_t mem [4];
  logic [1:0]    wr_ptr;
  logic [1:0]    rd_ptr;
  logic [2:0]    count;
  logic          do_pop;

  assign head_valid    = (count != 3'd0);
  assign head          = mem[rd_ptr];
  assign do_pop        = pop && head_valid;
  // room for two more items is needed before the next byte is taken
  assign status.count  = count;
  assign status.full   = (count > 3'd2);

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) mem[wr_ptr] <= push0;
    if (push_cnt == 2'd2) mem[wr_ptr + 2'd1] <= push1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      wr_ptr <= wr_ptr + push_cnt;
      if (do_pop) rd_ptr <= rd_ptr + 2'd1;
      count <= count + {1'b0, push_cnt} - {2'b0, do_pop};
    end
  end

endmodule

### rtl/script_token_scanner.sv
// script token scanner: one source byte per cycle in, tokens out through a small queue
// a token is queued when the byte that completes it is taken, and is offered from the queue head
// throughput: one byte per cycle while the queue has room for two tokens; a byte
// making two tokens sends them one after the other through the single output port
// reset (rst, synchronous): scanner idle, location counters zero, queue empty
// depends on sts_pkg, sts_step, sts_outq
module script_token_scanner (
  input  logic        clk,
  input  logic        rst,
  input  logic        source_valid,
  output logic        source_stall,
  input  logic [7:0]  source_byte,
  output logic        token_valid,
  input  logic        token_stall,
  output logic [5:0]  token_kind,
  output logic [15:0] start_position,
  output logic [15:0] start_line,
  output logic [15:0] start_column,
  output logic [15:0] token_length,
  output logic        last_of_run
);

  sts_pkg::state_t    st;
  sts_pkg::state_t    st_next;
  sts_pkg::tok_t      res0;
  sts_pkg::tok_t      res1;
  sts_pkg::tok_t      head;
  sts_pkg::q_status_t qstat;
  logic [1:0]         res_cnt;
  logic               accept;

  assign source_stall = qstat.full;
  assign accept       = source_valid && !source_stall;

  sts_step u_step (
    .c       (source_byte),
    .st      (st),
    .st_next (st_next),
    .res0    (res0),
    .res1    (res1),
    .res_cnt (res_cnt)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (accept) begin
      st <= st_next;
    end
  end

  sts_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .push_cnt   (accept ? res_cnt : 2'd0),
    .push0      (res0),
    .push1      (res1),
    .pop        (!token_stall),
    .head_valid (token_valid),
    .head       (head),
    .status     (qstat)
  );

  assign token_kind     = head.kind;
  assign start_position = head.pos;
  assign start_line     = head.line;
  assign start_column   = head.col;
  assign token_length   = head.len;
  assign last_of_run    = head.last;

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    qstat.count <= 3'd4)
    else $error("result queue count out of range");

  a_end_queued: assert property (@(posedge clk) disable iff (rst)
    (accept && source_byte == 8'd0) |=> token_valid)
    else $error("end of stream gave no token");

  a_end_idle: assert property (@(posedge clk) disable iff (rst)
    (accept && source_byte == 8'd0) |=> (st.mode == sts_pkg::MODE_IDLE))
    else $error("scanner not idle after end of stream");

  a_location_hold: assert property (@(posedge clk) disable iff (rst)
    (accept && source_byte == 8'd0 && st.mode != sts_pkg::MODE_STRING &&
     st.mode != sts_pkg::MODE_IDLE) |=> $stable(st.pos) || st.pos == $past(st.pos))
    else $error("end of stream moved the location");

endmodule
